// ===== rtl/hrrn_process_scheduler_macros.svh =====
// Assertion macros shared by the scheduler RTL.
`ifndef HRRN_PROCESS_SCHEDULER_MACROS_SVH
`define HRRN_PROCESS_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HRRN_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HRRN_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hrrn_pkg.sv =====
// Package: shared constants and the sequencer state type of the HRRN scheduler.
`default_nettype none

package hrrn_pkg;

    localparam int PROC_W      = 8;
    localparam int BURST_IN_W  = 16;
    localparam int COUNT_OUT_W = 5;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_ARRIVE = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_ARRIVE = 6'b000010,
        ST_READ   = 6'b000100,
        ST_MUL    = 6'b001000,
        ST_CMP    = 6'b010000,
        ST_DONE   = 6'b100000
    } hrrn_state_t;

endpackage

`default_nettype wire

// ===== rtl/hrrn_ratio_cmp.sv =====
// Response-ratio comparator: registered cross products, compare on the next cycle.
`default_nettype none

module hrrn_ratio_cmp #(
    parameter int TIME_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 load,
    input  wire logic [TIME_BITS-1:0] cand_wait,
    input  wire logic [TIME_BITS-1:0] cand_rem,
    input  wire logic [TIME_BITS-1:0] best_wait,
    input  wire logic [TIME_BITS-1:0] best_rem,
    output logic                      above
);

    localparam int PROD_W = 2 * TIME_BITS;

    logic [PROD_W-1:0] prod_cand_reg;
    logic [PROD_W-1:0] prod_best_reg;
    logic              cand_zero_reg;
    logic              best_zero_reg;

    // ratio (w+b)/b compared as w_c*b_b > w_b*b_c
    always_ff @(posedge aclk) begin
        if (load) begin
            prod_cand_reg <= PROD_W'(cand_wait) * PROD_W'(best_rem);
            prod_best_reg <= PROD_W'(best_wait) * PROD_W'(cand_rem);
            cand_zero_reg <= (cand_rem == '0);
            best_zero_reg <= (best_rem == '0);
        end
    end

    // zero burst ranks above every nonzero burst; two zeros tie
    always_comb begin
        if (cand_zero_reg) begin
            above = !best_zero_reg;
        end else if (best_zero_reg) begin
            above = 1'b0;
        end else begin
            above = (prod_cand_reg > prod_best_reg);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hrrn_process_scheduler.sv =====
// Top level: non-preemptive highest-response-ratio-next process scheduler.
`default_nettype none
`include "hrrn_process_scheduler_macros.svh"

// Every accepted item (s_opcode 1 = arrival, 0 = tick) returns exactly one
// result item: the running process after the item, whether an arrival was
// dropped on a full table, and how many processes wait. An arrival takes the
// lowest free slot with zero wait. A tick walks every slot of the slot memory
// once, after ST_READ fetches slot 0: per slot, products go into the shared
// cross-multiply comparator (ST_MUL), then compare and wait write-back
// (ST_CMP), and ST_DONE ends the walk. The walk is paced by the single read
// port of the slot memory and the one comparator. The same pass picks the
// dispatch candidate by exact integer cross products (ties to the lowest
// slot) and bumps every wait, saturating at 2^TIME_BITS-1. One item is in
// work at a time; s_ready is high whenever the sequencer is idle, even while
// a result still sits in the output register. Slot memory contents need no
// clearing after reset: a slot is used for ranking only when its valid flop
// is set.
module hrrn_process_scheduler
    import hrrn_pkg::*;
#(
    parameter int NUM_SLOTS = 16,
    parameter int TIME_BITS = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // input item channel
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic                   s_opcode,
    input  wire logic [PROC_W-1:0]      s_proc_id,
    input  wire logic [BURST_IN_W-1:0]  s_burst_time,
    // result item channel
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic                        m_running_valid,
    output logic [PROC_W-1:0]           m_running_id,
    output logic                        m_arrival_dropped,
    output logic [COUNT_OUT_W-1:0]      m_waiting_count
);

    localparam int IDX_W     = $clog2(NUM_SLOTS);
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
    localparam int ENT_W     = PROC_W + 2 * TIME_BITS;
    localparam int BURST_X_W = (TIME_BITS > BURST_IN_W) ? TIME_BITS : BURST_IN_W;
    localparam int CNT_X_W   = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;

    // ---------------- control state ----------------
    hrrn_state_t            state_reg, state_next;
    logic [NUM_SLOTS-1:0]   slot_valid_reg, slot_valid_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   run_active_reg, run_active_next;
    logic [PROC_W-1:0]      run_proc_reg, run_proc_next;
    logic [TIME_BITS-1:0]   run_left_reg, run_left_next;
    logic                   m_valid_reg, m_valid_next;

    // ---------------- item / scan payload ----------------
    logic                   op_reg, op_next;
    logic [PROC_W-1:0]      pid_reg, pid_next;
    logic [TIME_BITS-1:0]   burst_reg, burst_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic                   disp_reg, disp_next;
    logic                   best_found_reg, best_found_next;
    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    logic [PROC_W-1:0]      best_proc_reg, best_proc_next;
    logic [TIME_BITS-1:0]   best_rem_reg, best_rem_next;
    logic [TIME_BITS-1:0]   best_wait_reg, best_wait_next;

    // ---------------- result register ----------------
    logic                   out_rv_reg, out_rv_next;
    logic [PROC_W-1:0]      out_id_reg, out_id_next;
    logic                   out_drop_reg, out_drop_next;
    logic [COUNT_OUT_W-1:0] out_cnt_reg, out_cnt_next;

    // ---------------- slot memory: {proc, remaining, wait} ----------------
    logic [ENT_W-1:0]       mem [NUM_SLOTS];
    logic [ENT_W-1:0]       rd_data_reg;
    logic                   mem_re, mem_we;
    logic [IDX_W-1:0]       mem_raddr, mem_waddr;
    logic [ENT_W-1:0]       mem_wdata;

    logic [PROC_W-1:0]      rd_proc;
    logic [TIME_BITS-1:0]   rd_rem;
    logic [TIME_BITS-1:0]   rd_wait;
    logic [TIME_BITS-1:0]   wait_inc;

    logic                   out_free;
    logic                   last_slot;
    logic                   cur_valid;
    logic                   cand_above;
    logic                   take;
    logic                   free_any;
    logic [IDX_W-1:0]       free_idx;
    logic [BURST_X_W-1:0]   burst_ext;
    logic [CNT_X_W-1:0]     cnt_ext;

    assign rd_proc  = rd_data_reg[ENT_W-1 -: PROC_W];
    assign rd_rem   = rd_data_reg[2*TIME_BITS-1 -: TIME_BITS];
    assign rd_wait  = rd_data_reg[TIME_BITS-1:0];
    assign wait_inc = (&rd_wait) ? rd_wait : rd_wait + 1'b1;

    assign out_free  = !m_valid_reg || m_ready;
    assign last_slot = (idx_reg == IDX_W'(NUM_SLOTS - 1));
    assign cur_valid = slot_valid_reg[idx_reg];
    assign burst_ext = BURST_X_W'(s_burst_time);

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_running_valid   = out_rv_reg;
    assign m_running_id      = out_id_reg;
    assign m_arrival_dropped = out_drop_reg;
    assign m_waiting_count   = out_cnt_reg;

    // lowest free slot
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!slot_valid_reg[i]) begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    hrrn_ratio_cmp #(
        .TIME_BITS (TIME_BITS)
    ) u_cmp (
        .aclk      (aclk),
        .load      (state_reg == ST_MUL),
        .cand_wait (rd_wait),
        .cand_rem  (rd_rem),
        .best_wait (best_wait_reg),
        .best_rem  (best_rem_reg),
        .above     (cand_above)
    );

    // strict ">" keeps the lower slot on a tie
    assign take = disp_reg && cur_valid && (!best_found_reg || cand_above);

    // memory port control: read next slot while writing back the current one
    always_comb begin
        mem_re    = (state_reg == ST_READ) || ((state_reg == ST_CMP) && !last_slot);
        mem_raddr = (state_reg == ST_CMP) ? idx_reg + 1'b1 : idx_reg;
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = {rd_proc, rd_rem, wait_inc};
        if (state_reg == ST_ARRIVE) begin
            mem_we    = out_free && free_any;
            mem_waddr = free_idx;
            mem_wdata = {pid_reg, burst_reg, {TIME_BITS{1'b0}}};
        end else if (state_reg == ST_CMP) begin
            mem_we = cur_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        slot_valid_next = slot_valid_reg;
        count_next      = count_reg;
        run_active_next = run_active_reg;
        run_proc_next   = run_proc_reg;
        run_left_next   = run_left_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        op_next         = op_reg;
        pid_next        = pid_reg;
        burst_next      = burst_reg;
        idx_next        = idx_reg;
        disp_next       = disp_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_proc_next  = best_proc_reg;
        best_rem_next   = best_rem_reg;
        best_wait_next  = best_wait_reg;
        out_rv_next     = out_rv_reg;
        out_id_next     = out_id_reg;
        out_drop_next   = out_drop_reg;
        out_cnt_next    = out_cnt_reg;
        cnt_ext         = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next         = s_opcode;
                    pid_next        = s_proc_id;
                    burst_next      = burst_ext[TIME_BITS-1:0];
                    idx_next        = '0;
                    best_found_next = 1'b0;
                    disp_next       = !run_active_reg || (run_left_reg == '0);
                    state_next      = (s_opcode == OP_ARRIVE) ? ST_ARRIVE : ST_READ;
                end
            end
            ST_ARRIVE: begin
                if (out_free) begin
                    if (free_any) begin
                        slot_valid_next[free_idx] = 1'b1;
                        count_next                = count_reg + 1'b1;
                    end
                    out_drop_next = !free_any;
                    m_valid_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_READ: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (take) begin
                    best_found_next = 1'b1;
                    best_idx_next   = idx_reg;
                    best_proc_next  = rd_proc;
                    best_rem_next   = rd_rem;
                    best_wait_next  = rd_wait;
                end
                if (last_slot) begin
                    state_next = ST_DONE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    if (disp_reg) begin
                        if (best_found_reg) begin
                            run_active_next               = 1'b1;
                            run_proc_next                 = best_proc_reg;
                            run_left_next                 = (best_rem_reg == '0) ?
                                                            '0 : best_rem_reg - 1'b1;
                            slot_valid_next[best_idx_reg] = 1'b0;
                            count_next                    = count_reg - 1'b1;
                        end else begin
                            run_active_next = 1'b0;
                            run_proc_next   = '0;
                            run_left_next   = '0;
                        end
                    end else begin
                        run_left_next = (run_left_reg == '0) ? '0 : run_left_reg - 1'b1;
                    end
                    out_drop_next = 1'b0;
                    m_valid_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // result fields follow the state after the item
        cnt_ext      = CNT_X_W'(count_next);
        out_rv_next  = run_active_next;
        out_id_next  = run_active_next ? run_proc_next : '0;
        out_cnt_next = cnt_ext[COUNT_OUT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            slot_valid_reg <= '0;
            count_reg      <= '0;
            run_active_reg <= 1'b0;
            run_proc_reg   <= '0;
            run_left_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            slot_valid_reg <= slot_valid_next;
            count_reg      <= count_next;
            run_active_reg <= run_active_next;
            run_proc_reg   <= run_proc_next;
            run_left_reg   <= run_left_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        pid_reg        <= pid_next;
        burst_reg      <= burst_next;
        idx_reg        <= idx_next;
        disp_reg       <= disp_next;
        best_found_reg <= best_found_next;
        best_idx_reg   <= best_idx_next;
        best_proc_reg  <= best_proc_next;
        best_rem_reg   <= best_rem_next;
        best_wait_reg  <= best_wait_next;
        out_rv_reg     <= out_rv_next;
        out_id_reg     <= out_id_next;
        out_drop_reg   <= out_drop_next;
        out_cnt_reg    <= out_cnt_next;
    end

    // ---------------- assertions ----------------
    `HRRN_ASSERT_NOW(a_count_matches_valid, aclk, aresetn, 1'b1,
        count_reg == CNT_W'($countones(slot_valid_reg)), "waiting count out of step")
    `HRRN_ASSERT_NOW(a_no_rw_same_slot, aclk, aresetn, mem_we && mem_re,
        mem_waddr != mem_raddr, "slot memory read and write hit one entry")
    `HRRN_ASSERT_NOW(a_dispatch_from_valid, aclk, aresetn,
        (state_reg == ST_DONE) && out_free && disp_reg && best_found_reg,
        slot_valid_reg[best_idx_reg], "dispatch from an empty slot")
    `HRRN_ASSERT_NOW(a_idle_id_zero, aclk, aresetn, m_valid && !m_running_valid,
        m_running_id == '0, "running id nonzero with nothing running")
    `HRRN_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready,
        !s_ready, "second item taken while one is in work")

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Testbench for the HRRN process scheduler: directed table plus random traffic checked against a predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hrrn_pkg::*;

    localparam int CLK_PERIOD      = 4;
    localparam int RESET_CYCLES    = 6;
    localparam int SLOTS           = 16;
    localparam int RANDOM_ITEMS    = 950;
    localparam int CALM_ITEMS      = 150;   // tail of the run with no idling at all
    localparam int BIG_BURST_ITEMS = 120;   // tail where arrivals may carry huge bursts
    localparam int HOLD_OFF_CYCLES = 400;   // one long receiver stall to back up the input
    localparam int WATCHDOG_LIMIT  = 3000;  // idle cycles tolerated before giving up
    localparam int DRAIN_CYCLES    = 80;    // grace period after the last result, to catch strays

    // One input item and one result item, in port order.
    typedef struct packed {
        logic                   opcode;
        logic [PROC_W-1:0]      pid;
        logic [BURST_IN_W-1:0]  burst;
    } sched_item_t;

    typedef struct packed {
        logic                   running;
        logic [PROC_W-1:0]      running_id;
        logic                   dropped;
        logic [COUNT_OUT_W-1:0] waiting;
    } sched_result_t;

    // Directed row: item, a flag that says the result is typed in, and that result.
    typedef struct packed {
        sched_item_t   item;
        logic          typed;
        sched_result_t result;
    } directed_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_opcode;
    logic [PROC_W-1:0]      s_proc_id;
    logic [BURST_IN_W-1:0]  s_burst_time;
    logic                   m_valid;
    logic                   m_ready;
    logic                   m_running_valid;
    logic [PROC_W-1:0]      m_running_id;
    logic                   m_arrival_dropped;
    logic [COUNT_OUT_W-1:0] m_waiting_count;

    hrrn_process_scheduler dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_proc_id         (s_proc_id),
        .s_burst_time      (s_burst_time),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_running_valid   (m_running_valid),
        .m_running_id      (m_running_id),
        .m_arrival_dropped (m_arrival_dropped),
        .m_waiting_count   (m_waiting_count)
    );

    // ------------------------------------------------------------------
    // Scheduler predictor state. Zero-initialized bits match the reset
    // state: no slot waiting, nothing running.
    // ------------------------------------------------------------------
    bit                  pool_used  [SLOTS];
    bit [PROC_W-1:0]     pool_pid   [SLOTS];
    bit [BURST_IN_W-1:0] pool_burst [SLOTS];
    bit [BURST_IN_W-1:0] pool_wait  [SLOTS];
    bit                  cpu_busy;
    bit [PROC_W-1:0]     cpu_pid;
    bit [BURST_IN_W-1:0] cpu_left;

    sched_result_t expected_q [$];   // predicted results, oldest first
    sched_result_t want_result;
    int            failures;
    int            quiet_cycles;

    // Knobs the stimulus process sets per segment; the receiver reads them.
    int            tx_gap_pct;
    int            rx_stall_pct;
    bit            hold_off_req;

    // Directed table. Typed rows: the idle tick after reset, the first
    // arrivals (table counts), the zero-burst dispatch and the full-table
    // drop. Everything else goes through the predictor.
    directed_row_t directed_rows [25] = '{
        // empty scheduler: tick does nothing
        {OP_TICK,   8'h00, 16'h0000, 1'b1, 1'b0, 8'h00, 1'b0, 5'd0},
        {OP_ARRIVE, 8'hFF, 16'h0080, 1'b1, 1'b0, 8'h00, 1'b0, 5'd1},
        {OP_ARRIVE, 8'h00, 16'h0000, 1'b1, 1'b0, 8'h00, 1'b0, 5'd2},
        {OP_ARRIVE, 8'hA5, 16'h0003, 1'b1, 1'b0, 8'h00, 1'b0, 5'd3},
        // zero burst outranks everything; tick fields are junk on purpose
        {OP_TICK,   8'h3C, 16'hFFFF, 1'b1, 1'b1, 8'h00, 1'b0, 5'd2},
        // running job already at zero: replaced by the best ratio
        {OP_TICK,   8'hC3, 16'h5A5A, 1'b0, 1'b0, 8'h00, 1'b0, 5'd0},
        // refill the table; two zero bursts land in slots 1 and 3
        {OP_ARRIVE, 8'h01, 16'h0000, 1'b0, 1'b0, 8'h00, 1'b0, 5'd0},
        {OP_ARRIVE, 8'h02, 16'h0004, 1'b0, 1'b0, 8'h00, 1'b0, 5'd0},
        {OP_ARRIVE, 8'h03, 16'h0000, 1'b0, 1'b0, 8'h00, 1'b0, 5'd0},
        {OP_ARRIVE, 8'h04, 16'h0001, 1'b0, 1'b0, 8'h00, 1'b0, 5'd0},
        {OP_ARRIVE, 8'h05, 16'h0002, 1'b0, 1'b0, 8'h00, 1'b0, 5'd0},
        {OP_ARRIVE, 8'h06, 16'h0007, 1'b0, 1'b0, 8'h00, 1'b0, 5'd0},
        {OP_ARRIVE, 8'h07, 16'h0003, 1'b0, 1'b0, 8'h00, 1'b0, 5'd0},
        {OP_ARRIVE, 8'h08, 16'h0010, 1'b0, 1'b0, 8'h00, 1'b0, 5'd0},
        {OP_ARRIVE, 8'h09, 16'h0005, 1'b0, 1'b0, 8'h00, 1'b0, 5'd0},
        {OP_ARRIVE, 8'h0A, 16'h0006, 1'b0, 1'b0, 8'h00, 1'b0, 5'd0},
        {OP_ARRIVE, 8'h0B, 16'h0001, 1'b0, 1'b0, 8'h00, 1'b0, 5'd0},
        {OP_ARRIVE, 8'h0C, 16'h0002, 1'b0, 1'b0, 8'h00, 1'b0, 5'd0},
        {OP_ARRIVE, 8'h0D, 16'h003C, 1'b0, 1'b0, 8'h00, 1'b0, 5'd0},
        {OP_ARRIVE, 8'h0E, 16'h0009, 1'b0, 1'b0, 8'h00, 1'b0, 5'd0},
        {OP_ARRIVE, 8'h80, 16'h0008, 1'b0, 1'b0, 8'h00, 1'b0, 5'd0},
        // table full: dropped, running job untouched
        {OP_ARRIVE, 8'h5A, 16'hFFFF, 1'b1, 1'b1, 8'hA5, 1'b1, 5'd16},
        // run the current job down, then the zero-burst tie goes to slot 1
        {OP_TICK,   8'hFF, 16'h8000, 1'b0, 1'b0, 8'h00, 1'b0, 5'd0},
        {OP_TICK,   8'h00, 16'h7FFF, 1'b0, 1'b0, 8'h00, 1'b0, 5'd0},
        {OP_TICK,   8'h55, 16'h00FF, 1'b0, 1'b0, 8'h00, 1'b0, 5'd0}
    };

    // True when slot a has a strictly higher response ratio than slot b.
    // (w+b)/b = 1 + w/b, so compare w_a*b_b against w_b*b_a; zero burst
    // means an unbounded ratio.
    function automatic bit outranks(int a, int b);
        logic [31:0] lhs;
        logic [31:0] rhs;
        if (pool_burst[a] == '0)
            return pool_burst[b] != '0;
        if (pool_burst[b] == '0)
            return 1'b0;
        lhs = 32'(pool_wait[a]) * 32'(pool_burst[b]);
        rhs = 32'(pool_wait[b]) * 32'(pool_burst[a]);
        return lhs > rhs;
    endfunction

    // Apply one accepted item to the predictor and return its result.
    function automatic sched_result_t schedule_step(sched_item_t it);
        sched_result_t res;
        int            free_slot;
        int            best;
        int            waiting;
        res       = '0;
        free_slot = -1;
        best      = -1;
        waiting   = 0;
        if (it.opcode == OP_ARRIVE) begin
            for (int i = 0; i < SLOTS; i++)
                if (!pool_used[i] && free_slot < 0)
                    free_slot = i;
            if (free_slot < 0) begin
                res.dropped = 1'b1;
            end else begin
                pool_used[free_slot]  = 1'b1;
                pool_pid[free_slot]   = it.pid;
                pool_burst[free_slot] = it.burst;
                pool_wait[free_slot]  = '0;
            end
        end else begin
            // dispatch only when idle or the running job is used up
            if (!cpu_busy || cpu_left == '0) begin
                for (int i = 0; i < SLOTS; i++)
                    if (pool_used[i] && (best < 0 || outranks(i, best)))
                        best = i;
                if (best >= 0) begin
                    cpu_busy        = 1'b1;
                    cpu_pid         = pool_pid[best];
                    cpu_left        = pool_burst[best];
                    pool_used[best] = 1'b0;
                end else begin
                    cpu_busy = 1'b0;
                    cpu_pid  = '0;
                    cpu_left = '0;
                end
            end
            // time only passes while something runs; both counters saturate
            if (cpu_busy) begin
                if (cpu_left != '0)
                    cpu_left--;
                for (int i = 0; i < SLOTS; i++)
                    if (pool_used[i] && pool_wait[i] != '1)
                        pool_wait[i]++;
            end
        end
        for (int i = 0; i < SLOTS; i++)
            if (pool_used[i])
                waiting++;
        res.running    = cpu_busy;
        res.running_id = cpu_busy ? cpu_pid : '0;
        res.waiting    = waiting[COUNT_OUT_W-1:0];
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endfunction

    // Present one item at the falling edge, optionally after an idle burst,
    // hold it until accepted, then record what the scheduler should answer.
    task automatic offer(input sched_item_t it, input bit typed,
                         input sched_result_t typed_result);
        sched_result_t predicted;
        @(negedge aclk);
        if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_opcode     <= it.opcode;
        s_proc_id    <= it.pid;
        s_burst_time <= it.burst;
        do @(posedge aclk); while (!s_ready);
        predicted = schedule_step(it);
        expected_q.push_back(typed ? typed_result : predicted);
    endtask

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Result side: m_ready idles in random bursts, and once takes a long
    // hold-off so the scheduler's output register fills and s_ready drops.
    // ------------------------------------------------------------------
    initial begin
        int stall_left;
        m_ready    = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_OFF_CYCLES;
            end else if (stall_left == 0 && rx_stall_pct != 0 &&
                         $urandom_range(0, 99) < rx_stall_pct) begin
                stall_left = $urandom_range(1, 16);
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Result checker: every accepted result item against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $error("result item with no expectation pending");
                failures++;
            end else begin
                want_result = expected_q.pop_front();
                check_field("running_valid", 32'(want_result.running),
                            32'(m_running_valid));
                check_field("running_id", 32'(want_result.running_id),
                            32'(m_running_id));
                check_field("arrival_dropped", 32'(want_result.dropped),
                            32'(m_arrival_dropped));
                check_field("waiting_count", 32'(want_result.waiting),
                            32'(m_waiting_count));
            end
        end
    end

    // Watchdog: ends the run when neither channel moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: reset, directed table, then segmented random traffic.
    // ------------------------------------------------------------------
    initial begin
        sched_item_t it;
        int          seg_left;
        int          arrive_pct;
        int          r;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_opcode     = OP_TICK;
        s_proc_id    = '0;
        s_burst_time = '0;
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        hold_off_req = 1'b0;
        seg_left     = 0;
        arrive_pct   = 50;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part with moderate idling on both sides
        tx_gap_pct   = 20;
        rx_stall_pct = 10;
        foreach (directed_rows[i])
            offer(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);

        // Random part in segments. Each segment picks an arrival mix (fill
        // the table and drop, balanced, or drain and idle) and idling rates,
        // some of them zero. Bursts stay short so jobs finish and dispatch
        // keeps happening; huge bursts only show up near the end, where a
        // job that never finishes costs nothing.
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(15, 60);
                case ($urandom_range(0, 2))
                    0: arrive_pct = 20;
                    1: arrive_pct = 50;
                    default: arrive_pct = 80;
                endcase
                case ($urandom_range(0, 2))
                    0: tx_gap_pct = 0;
                    1: tx_gap_pct = 15;
                    default: tx_gap_pct = 40;
                endcase
                case ($urandom_range(0, 2))
                    0: rx_stall_pct = 0;
                    1: rx_stall_pct = 5;
                    default: rx_stall_pct = 20;
                endcase
            end
            seg_left--;
            if (k == 0) begin
                // long receiver hold-off while the sender keeps pushing items
                tx_gap_pct   = 0;
                hold_off_req = 1'b1;
            end
            if (k >= RANDOM_ITEMS - CALM_ITEMS) begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end

            it.opcode = ($urandom_range(0, 99) < arrive_pct) ? OP_ARRIVE : OP_TICK;
            it.pid    = PROC_W'($urandom_range(0, 255));
            r         = $urandom_range(0, 99);
            if (it.opcode == OP_TICK)
                it.burst = BURST_IN_W'($urandom_range(0, 16'hFFFF));   // ignored, toggles bits
            else if (r < 15)
                it.burst = '0;
            else if (r < 70)
                it.burst = BURST_IN_W'($urandom_range(1, 4));
            else if (r < 90)
                it.burst = BURST_IN_W'($urandom_range(5, 16));
            else if (k >= RANDOM_ITEMS - BIG_BURST_ITEMS)
                it.burst = BURST_IN_W'($urandom_range(16'h8000, 16'hFFFF));
            else
                it.burst = BURST_IN_W'($urandom_range(17, 64));
            offer(it, 1'b0, '0);
        end

        @(negedge aclk);
        s_valid <= 1'b0;

        // wait for every expected result, then a grace period for strays
        while (expected_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
